>>> rtl/core/neighbour_color_diff_weight_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the neighbour colour difference weight unit
// Clocked implication forms used by the checker file.
// ----------------------------------------------------------------------------
`ifndef NEIGHBOUR_COLOR_DIFF_WEIGHT_UNIT_DEFINES_SVH
`define NEIGHBOUR_COLOR_DIFF_WEIGHT_UNIT_DEFINES_SVH

// same-cycle implication
`define NCDW_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NCDW_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/ncdw_pkg.sv
// ----------------------------------------------------------------------------
// ncdw_pkg
// Types, constants and tables of the neighbour colour difference weight unit.
// ----------------------------------------------------------------------------
package ncdw_pkg;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [1:0] {
		REG_SIGMA  = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2
	} reg_idx_t;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int SIGMA_W    = 16;
	localparam int SIZE_W     = 9;
	localparam int COORD_W    = 8;
	localparam int CHAN_W     = 8;
	localparam int PIX_W      = 3 * CHAN_W;
	localparam int SUM_W      = 13;
	localparam int WEIGHT_W   = 16;
	localparam int FRAC_W     = 32;
	localparam int DIV_W      = 48;
	localparam int DIV_RADIX  = 4;
	localparam int DIV_STEPS  = DIV_W / DIV_RADIX;
	localparam int TERMS      = 12;
	localparam int K_LIMIT    = 12;
	localparam int ACC_W      = 35;
	localparam int MUL_A_W    = 33;
	localparam int MUL_B_W    = 32;
	localparam int MUL_W      = MUL_A_W + MUL_B_W;
	localparam int RECIP_W    = 36;

	localparam logic [SIGMA_W-1:0] SIGMA_RESET     = 16'd300;
	localparam logic [SUM_W-1:0]   SUM_MAX         = 13'd6120;
	localparam logic [32:0]        ONE_Q32         = 33'h1_0000_0000;
	localparam logic [31:0]        EXP_NEG_ONE_Q32 = 32'd1580030169;

	typedef struct packed {
		logic               opcode;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [CHAN_W-1:0]  chan_a;
		logic [CHAN_W-1:0]  chan_b;
		logic [CHAN_W-1:0]  chan_c;
	} in_item_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0] weight;
		logic [SUM_W-1:0]    diff_sum;
	} out_item_t;

	typedef struct packed {
		logic       wr_pixel;
		logic       capture;
		logic       rd_en;
		logic [3:0] rd_idx;
		logic       div_start;
		logic       div_step;
		logic       ser_init;
		logic       ser_mul;
		logic       ser_acc;
		logic       ser_neg;
		logic       ser_recip;
		logic       ser_quot;
		logic       ser_corr;
		logic [3:0] n;
		logic       clamp;
		logic       sc_mul;
		logic       sc_upd;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic       in_range;
		logic       is_query;
		logic       k_big;
		logic [3:0] k;
	} sts_t;

	// floor(2^35 / n): the series divides each term by n through this
	function automatic logic [RECIP_W-1:0] recip_q35(input logic [3:0] n);
		logic [RECIP_W-1:0] m;
		case (n)
			4'd1:    m = 36'd34359738368;
			4'd2:    m = 36'd17179869184;
			4'd3:    m = 36'd11453246122;
			4'd4:    m = 36'd8589934592;
			4'd5:    m = 36'd6871947673;
			4'd6:    m = 36'd5726623061;
			4'd7:    m = 36'd4908534052;
			4'd8:    m = 36'd4294967296;
			4'd9:    m = 36'd3817748707;
			4'd10:   m = 36'd3435973836;
			4'd11:   m = 36'd3123612578;
			4'd12:   m = 36'd2863311530;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

>>> rtl/core/ncdw_ctrl.sv
// ----------------------------------------------------------------------------
// ncdw_ctrl
// Sequencer: neighbour reads, division, series, scaling and result hand-off.
// ----------------------------------------------------------------------------
module ncdw_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  ncdw_pkg::sts_t sts,
	output ncdw_pkg::cmd_t cmd
);
	import ncdw_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_READ, S_DRAIN, S_DIVI, S_DIV, S_CHECK,
		S_T1, S_T2, S_T3, S_T4, S_ACC, S_CLAMP, S_SMUL, S_SUPD, S_DONE
	} state_t;

	localparam logic [3:0] LAST_RD  = 4'd8;
	localparam logic [3:0] LAST_DIV = 4'(DIV_STEPS - 1);
	localparam logic [3:0] N_LAST   = 4'(TERMS);

	state_t     state_q;
	logic [3:0] cnt_q;
	logic [3:0] n_q;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd   = '0;
		cmd.n = n_q;
		case (state_q)
			S_IDLE: begin
				cmd.wr_pixel = in_valid && sts.in_range && !sts.is_query;
				cmd.capture  = in_valid && sts.in_range && sts.is_query;
			end
			S_READ: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_idx = cnt_q;
			end
			S_DIVI:  cmd.div_start = 1'b1;
			S_DIV:   cmd.div_step  = 1'b1;
			S_CHECK: cmd.ser_init  = !sts.k_big;
			S_T1: begin
				// fold in the previous term: odd terms subtract
				cmd.ser_mul = 1'b1;
				cmd.ser_acc = (n_q != 4'd1);
				cmd.ser_neg = ~n_q[0];
			end
			S_T2:    cmd.ser_recip = 1'b1;
			S_T3:    cmd.ser_quot  = 1'b1;
			S_T4:    cmd.ser_corr  = 1'b1;
			S_ACC: begin
				cmd.ser_acc = 1'b1;
				cmd.ser_neg = n_q[0];
			end
			S_CLAMP: cmd.clamp    = 1'b1;
			S_SMUL:  cmd.sc_mul   = 1'b1;
			S_SUPD:  cmd.sc_upd   = 1'b1;
			S_DONE:  cmd.out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.capture) begin
						state_q <= S_READ;
						cnt_q   <= '0;
					end
				end
				S_READ: begin
					if (cnt_q == LAST_RD) begin
						state_q <= S_DRAIN;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				S_DRAIN: state_q <= S_DIVI;
				S_DIVI: begin
					state_q <= S_DIV;
					cnt_q   <= '0;
				end
				S_DIV: begin
					if (cnt_q == LAST_DIV) begin
						state_q <= S_CHECK;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				S_CHECK: begin
					if (sts.k_big) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_T1;
						n_q     <= 4'd1;
					end
				end
				S_T1: state_q <= S_T2;
				S_T2: state_q <= S_T3;
				S_T3: state_q <= S_T4;
				S_T4: begin
					if (n_q == N_LAST) begin
						state_q <= S_ACC;
					end else begin
						n_q     <= n_q + 4'd1;
						state_q <= S_T1;
					end
				end
				S_ACC: state_q <= S_CLAMP;
				S_CLAMP: begin
					cnt_q   <= sts.k;
					state_q <= (sts.k == 4'd0) ? S_DONE : S_SMUL;
				end
				S_SMUL: state_q <= S_SUPD;
				S_SUPD: begin
					cnt_q   <= cnt_q - 4'd1;
					state_q <= (cnt_q == 4'd1) ? S_DONE : S_SMUL;
				end
				S_DONE: begin
					if (cmd.out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/core/ncdw_div.sv
// ----------------------------------------------------------------------------
// ncdw_div
// Radix-16 restoring divider: (num << 32) / den, four quotient bits a step.
// ----------------------------------------------------------------------------
module ncdw_div (
	input  logic                          clk,
	input  logic                          start,
	input  logic                          step,
	input  logic [ncdw_pkg::SUM_W-1:0]    num,
	input  logic [ncdw_pkg::SIGMA_W-1:0]  den,
	output logic [ncdw_pkg::DIV_W-1:0]    quo
);
	import ncdw_pkg::*;

	logic [DIV_W-1:0]   dq_q;
	logic [DIV_W-1:0]   dq_n;
	logic [SIGMA_W-1:0] rem_q;
	logic [SIGMA_W-1:0] rem_n;

	// dq holds the unconsumed dividend at the top and quotient bits at the bottom
	always_comb begin
		logic [SIGMA_W:0] part;
		logic             ge;
		dq_n  = dq_q;
		rem_n = rem_q;
		for (int i = 0; i < DIV_RADIX; i++) begin
			part  = {rem_n, dq_n[DIV_W-1]};
			ge    = (part >= {1'b0, den});
			dq_n  = {dq_n[DIV_W-2:0], ge};
			rem_n = ge ? SIGMA_W'(part - {1'b0, den}) : part[SIGMA_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= DIV_W'({num, {FRAC_W{1'b0}}});
		end else if (step) begin
			rem_q <= rem_n;
			dq_q  <= dq_n;
		end
	end

	assign quo = dq_q;

endmodule

>>> rtl/core/ncdw_datapath.sv
// ----------------------------------------------------------------------------
// ncdw_datapath
// Frame store, neighbour difference sum, divider, series and scaling unit.
// ----------------------------------------------------------------------------
module ncdw_datapath #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ncdw_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [ncdw_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  ncdw_pkg::in_item_t               in_data,
	input  ncdw_pkg::cmd_t                   cmd,
	output ncdw_pkg::sts_t                   sts,
	output ncdw_pkg::out_item_t              out_data
);
	import ncdw_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [SIZE_W-1:0] W_LIM = SIZE_W'((MAX_WIDTH < 256) ? MAX_WIDTH : 256);
	localparam logic [SIZE_W-1:0] H_LIM = SIZE_W'((MAX_HEIGHT < 256) ? MAX_HEIGHT : 256);

	function automatic logic [SIZE_W-1:0] size_clamp(input logic [SIZE_W-1:0] v,
			input logic [SIZE_W-1:0] lim);
		logic [SIZE_W-1:0] r;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if (v > lim) begin
			r = lim;
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [AW-1:0] pix_addr(input logic [COORD_W-1:0] r,
			input logic [COORD_W-1:0] c);
		logic [31:0] a;
		a = 32'(r) * 32'(MAX_WIDTH) + 32'(c);
		return a[AW-1:0];
	endfunction

	function automatic logic [CHAN_W:0] abs_diff(input logic [CHAN_W-1:0] a,
			input logic [CHAN_W-1:0] b);
		logic [CHAN_W:0] d;
		d = (a > b) ? {1'b0, a - b} : {1'b0, b - a};
		return d;
	endfunction

	function automatic logic [9:0] pixel_diff(input logic [PIX_W-1:0] p,
			input logic [PIX_W-1:0] q);
		logic [9:0] s;
		s = 10'(abs_diff(p[7:0], q[7:0])) + 10'(abs_diff(p[15:8], q[15:8]))
			+ 10'(abs_diff(p[23:16], q[23:16]));
		return s;
	endfunction

	// configuration, held already clamped
	logic [SIGMA_W-1:0] sigma_q;
	logic [SIZE_W-1:0]  w_q;
	logic [SIZE_W-1:0]  h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q <= SIGMA_RESET;
			w_q     <= W_LIM;
			h_q     <= H_LIM;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SIGMA:  sigma_q <= (cfg_wdata == '0) ? SIGMA_W'(1) : cfg_wdata;
				REG_WIDTH:  w_q     <= size_clamp(cfg_wdata[SIZE_W-1:0], W_LIM);
				REG_HEIGHT: h_q     <= size_clamp(cfg_wdata[SIZE_W-1:0], H_LIM);
				default: ;
			endcase
		end
	end

	// neighbour coordinates, wrapped at the configured size
	logic [COORD_W-1:0] row_c_q, row_m_q, row_p_q;
	logic [COORD_W-1:0] col_c_q, col_m_q, col_p_q;
	logic [SIZE_W-1:0]  h_last, w_last;

	assign h_last = h_q - SIZE_W'(1);
	assign w_last = w_q - SIZE_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			row_c_q <= in_data.row;
			col_c_q <= in_data.col;
			row_m_q <= (in_data.row == '0) ? h_last[COORD_W-1:0] : in_data.row - 8'd1;
			col_m_q <= (in_data.col == '0) ? w_last[COORD_W-1:0] : in_data.col - 8'd1;
			row_p_q <= ({1'b0, in_data.row} == h_last) ? '0 : in_data.row + 8'd1;
			col_p_q <= ({1'b0, in_data.col} == w_last) ? '0 : in_data.col + 8'd1;
		end
	end

	// frame store: one write port for loads, one registered read port
	logic [PIX_W-1:0]   store_q [DEPTH];
	logic [PIX_W-1:0]   rd_data_s1;
	logic               rd_s1;
	logic               centre_s1;
	logic [COORD_W-1:0] rd_row, rd_col;
	logic [AW-1:0]      rd_addr, wr_addr;

	always_comb begin
		case (cmd.rd_idx)
			4'd0:    begin rd_row = row_c_q; rd_col = col_c_q; end
			4'd1:    begin rd_row = row_m_q; rd_col = col_m_q; end
			4'd2:    begin rd_row = row_m_q; rd_col = col_c_q; end
			4'd3:    begin rd_row = row_m_q; rd_col = col_p_q; end
			4'd4:    begin rd_row = row_c_q; rd_col = col_m_q; end
			4'd5:    begin rd_row = row_c_q; rd_col = col_p_q; end
			4'd6:    begin rd_row = row_p_q; rd_col = col_m_q; end
			4'd7:    begin rd_row = row_p_q; rd_col = col_c_q; end
			4'd8:    begin rd_row = row_p_q; rd_col = col_p_q; end
			default: begin rd_row = row_c_q; rd_col = col_c_q; end
		endcase
	end

	assign rd_addr = pix_addr(rd_row, rd_col);
	assign wr_addr = pix_addr(in_data.row, in_data.col);

	always_ff @(posedge clk) begin
		if (cmd.wr_pixel) begin
			store_q[wr_addr] <= {in_data.chan_c, in_data.chan_b, in_data.chan_a};
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= store_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1     <= 1'b0;
			centre_s1 <= 1'b0;
		end else begin
			rd_s1     <= cmd.rd_en;
			centre_s1 <= cmd.rd_en && (cmd.rd_idx == 4'd0);
		end
	end

	// difference sum; the centre comes back first
	logic [PIX_W-1:0] centre_q;
	logic [SUM_W-1:0] sum_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sum_q <= '0;
		end else if (rd_s1) begin
			if (centre_s1) begin
				centre_q <= rd_data_s1;
			end else begin
				sum_q <= sum_q + SUM_W'(pixel_diff(centre_q, rd_data_s1));
			end
		end
	end

	// sum / sigma as 16.32
	logic [DIV_W-1:0] quo;

	ncdw_div u_div (
		.clk   (clk),
		.start (cmd.div_start),
		.step  (cmd.div_step),
		.num   (sum_q),
		.den   (sigma_q),
		.quo   (quo)
	);

	logic [FRAC_W-1:0] frac;
	assign frac       = quo[FRAC_W-1:0];
	assign sts.k_big  = (quo[DIV_W-1:FRAC_W] >= 16'(K_LIMIT));
	assign sts.k      = quo[FRAC_W+3:FRAC_W];
	assign sts.in_range = ({1'b0, in_data.row} < h_q) && ({1'b0, in_data.col} < w_q);
	assign sts.is_query = (in_data.opcode == OP_QUERY);

	// Taylor series for exp(-frac); term/n through a reciprocal and one fix-up
	logic [32:0]             term_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] term_s;
	logic [31:0]             t_q;
	logic [RECIP_W-1:0]      thi_q;
	logic [31:0]             q0_q;
	logic [68:0]             qsum;
	logic [RECIP_W-1:0]      prodn;
	logic [RECIP_W-1:0]      rem;
	logic [32:0]             v_q;
	logic [MUL_W-1:0]        vr;

	// shared multiplier, registered
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_W-1:0]   mul_q;
	logic [RECIP_W-1:0] recip_m;

	assign recip_m = recip_q35(cmd.n);

	always_comb begin
		if (cmd.ser_mul) begin
			mul_a = term_q;
			mul_b = frac;
		end else if (cmd.ser_recip) begin
			mul_a = {1'b0, mul_q[63:32]};
			mul_b = recip_m[31:0];
		end else if (cmd.sc_mul) begin
			mul_a = v_q;
			mul_b = EXP_NEG_ONE_Q32;
		end else begin
			mul_a = '0;
			mul_b = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ser_mul || cmd.ser_recip || cmd.sc_mul) begin
			mul_q <= mul_a * mul_b;
		end
	end

	assign term_s = $signed({2'b00, term_q});
	assign qsum   = 69'(mul_q) + 69'({thi_q, 32'h0});
	assign prodn  = RECIP_W'(q0_q) * RECIP_W'(cmd.n);
	assign rem    = RECIP_W'(t_q) - prodn;
	assign vr     = mul_q + MUL_W'(33'h0_8000_0000);

	always_ff @(posedge clk) begin
		if (cmd.ser_init) begin
			term_q <= ONE_Q32;
			acc_q  <= $signed({2'b00, ONE_Q32});
		end else if (cmd.ser_acc) begin
			acc_q <= cmd.ser_neg ? acc_q - term_s : acc_q + term_s;
		end
		if (cmd.ser_recip) begin
			t_q   <= mul_q[63:32];
			thi_q <= RECIP_W'(mul_q[63:32]) * RECIP_W'(recip_m[RECIP_W-1:32]);
		end
		if (cmd.ser_quot) begin
			q0_q <= qsum[66:35];
		end
		if (cmd.ser_corr) begin
			term_q <= {1'b0, q0_q} + 33'(rem >= RECIP_W'(cmd.n));
		end
		if (cmd.clamp) begin
			if (acc_q < 0) begin
				v_q <= '0;
			end else if (acc_q > $signed({2'b00, ONE_Q32})) begin
				v_q <= ONE_Q32;
			end else begin
				v_q <= acc_q[32:0];
			end
		end else if (cmd.sc_upd) begin
			v_q <= vr[64:32];
		end
	end

	// rounding to 0.16 and the result register
	logic [33:0]         wsum;
	logic [17:0]         wfull;
	logic [WEIGHT_W-1:0] weight;
	out_item_t           out_q;

	assign wsum   = {1'b0, v_q} + 34'h0_0000_8000;
	assign wfull  = wsum[33:16];
	assign weight = sts.k_big ? '0 :
		(wfull > 18'd65535) ? '1 : wfull[WEIGHT_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.weight   <= weight;
			out_q.diff_sum <= sum_q;
		end
	end

	assign out_data = out_q;

endmodule

>>> rtl/core/neighbour_color_diff_weight_unit.sv
// ----------------------------------------------------------------------------
// neighbour_color_diff_weight_unit
// Eight-neighbour colour difference sum and exponential affinity weight.
// ----------------------------------------------------------------------------
// A load beat writes one 24-bit pixel; a load or query outside the configured
// width and height is dropped. A query runs longer the larger k is, with k =
// floor(diff_sum / sigma) from 0 to 11; at 12 or more the weight is 0.
// The bulk is the twelve-term series for exp(-fraction), each term a product,
// a reciprocal product, a quotient and a fix-up, the products on the one
// shared 33x32 multiplier; nine frame store reads on the one read port and
// twelve radix-16 divider steps make up most of the rest, and each power of
// exp(-1) adds a product and an update. A finished result waits in an output
// register, so the next item is taken while it is still unread. The frame
// store is not cleared: a query must only touch pixels that were loaded.
// Configuration may only be written while the unit is idle.
// ----------------------------------------------------------------------------
module neighbour_color_diff_weight_unit #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ncdw_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [ncdw_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  ncdw_pkg::in_item_t               in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output ncdw_pkg::out_item_t              out_data
);
	import ncdw_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ncdw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ncdw_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

endmodule

>>> rtl/core/ncdw_checker.sv
// ----------------------------------------------------------------------------
// ncdw_checker
// Port-level checks of the neighbour colour difference weight unit.
// ----------------------------------------------------------------------------
`include "neighbour_color_diff_weight_unit_defines.svh"

module ncdw_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input ncdw_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input ncdw_pkg::out_item_t out_data
);
	import ncdw_pkg::*;

	`NCDW_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result beat changed while stalled")
	`NCDW_ASSERT_NXT(a_load_silent, clk, arst_n, in_valid && in_ready && (in_data.opcode == OP_LOAD), !$rose(out_valid), "load beat produced a result")
	`NCDW_ASSERT_IMP(a_sum_range, clk, arst_n, out_valid, out_data.diff_sum <= SUM_MAX, "difference sum out of range")
	`NCDW_ASSERT_IMP(a_unity_weight, clk, arst_n, out_valid && (out_data.diff_sum == '0), out_data.weight == '1, "zero sum must give full weight")
	`NCDW_ASSERT_IMP(a_busy_before_result, clk, arst_n, $rose(out_valid), $past(!in_ready), "result appeared without a query in flight")

endmodule

bind neighbour_color_diff_weight_unit ncdw_checker u_ncdw_checker (.*);
